### src/ttv_pkg.sv
// ============================================================================
// ttv_pkg: shared types and constants for the triangle tangent vector block
// Holds the transaction payload structs, the normalized sideband record and
// the fixed widths that the pipeline stages agree on.
// ============================================================================
package ttv_pkg;

    // Texture coordinate component width and its difference width.
    localparam int UV_W   = 16;
    localparam int D_W    = UV_W + 1;

    // Normalized magnitude width; the largest one lands in [2^29, 2^30).
    localparam int R_W    = 30;
    localparam int R_TOP  = R_W - 1;

    // Sum of squares and its integer square root.
    localparam int SQ_W   = 2 * R_W;
    localparam int S_W    = 62;
    localparam int L_W    = 31;
    localparam int REM_W  = L_W + 2;

    // Division: numerator is 16384*r + L/2, quotient has 16 bits.
    localparam int FRAC_BITS = 14;
    localparam int NUM_W     = R_W + FRAC_BITS + 1;
    localparam int Q_W       = 16;
    localparam int OUT_W     = 16;
    localparam logic [Q_W-1:0] ONE_Q14 = 16'd16384;

    // Packed position field width on the input channel.
    localparam int POS_W  = 48;

    typedef struct packed {
        logic [POS_W-1:0] first_position;
        logic [POS_W-1:0] second_position;
        logic [POS_W-1:0] third_position;
        logic [31:0]      first_uv;
        logic [31:0]      second_uv;
        logic [31:0]      third_uv;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] tangent_x;
        logic signed [OUT_W-1:0] tangent_y;
        logic signed [OUT_W-1:0] tangent_z;
        logic                    degenerate;
    } out_t;

    // Normalized tangent magnitudes with their final signs.
    typedef struct packed {
        logic                  degen;
        logic [2:0]            neg;
        logic [2:0][R_W-1:0]   r;
    } side_t;

endpackage

### src/ttv_front.sv
// ============================================================================
// ttv_front: edge vectors, UV determinant and magnitude normalization
// Six register stages: differences, products, cross terms and magnitudes,
// maximum, leading-one position, and the common normalizing shift.
// ============================================================================
module ttv_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  ttv_pkg::in_t   in_data,
    output logic           out_valid,
    output ttv_pkg::side_t out_side
);
    import ttv_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int EW   = W + 1;
    localparam int PW   = (3 * W > POS_W) ? 3 * W : POS_W;
    localparam int PRW  = W + 18;
    localparam int NW   = W + 19;
    localparam int MW   = W + 18;
    localparam int PSW  = $clog2(MW);
    localparam int DETW = 2 * D_W + 1;

    // Stage 1: edges and UV deltas.
    logic signed [EW-1:0]  e1_reg [3], e2_reg [3];
    logic signed [EW-1:0]  e1_next [3], e2_next [3];
    logic signed [D_W-1:0] d1u_reg, d1v_reg, d2u_reg, d2v_reg;
    logic signed [D_W-1:0] d1u_next, d1v_next, d2u_next, d2v_next;
    logic                  v1_reg;

    logic [PW-1:0] pos_ext [3];
    logic signed [W-1:0]    pc [3][3];
    logic signed [UV_W-1:0] tc [3][2];

    always_comb begin
        pos_ext[0] = PW'(in_data.first_position);
        pos_ext[1] = PW'(in_data.second_position);
        pos_ext[2] = PW'(in_data.third_position);
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                pc[i][k] = signed'(pos_ext[i][k*W +: W]);
            end
        end
        tc[0][0] = signed'(in_data.first_uv[UV_W-1:0]);
        tc[0][1] = signed'(in_data.first_uv[2*UV_W-1:UV_W]);
        tc[1][0] = signed'(in_data.second_uv[UV_W-1:0]);
        tc[1][1] = signed'(in_data.second_uv[2*UV_W-1:UV_W]);
        tc[2][0] = signed'(in_data.third_uv[UV_W-1:0]);
        tc[2][1] = signed'(in_data.third_uv[2*UV_W-1:UV_W]);
        for (int k = 0; k < 3; k++) begin
            e1_next[k] = EW'(pc[1][k]) - EW'(pc[0][k]);
            e2_next[k] = EW'(pc[2][k]) - EW'(pc[0][k]);
        end
        d1u_next = D_W'(tc[1][0]) - D_W'(tc[0][0]);
        d1v_next = D_W'(tc[1][1]) - D_W'(tc[0][1]);
        d2u_next = D_W'(tc[2][0]) - D_W'(tc[0][0]);
        d2v_next = D_W'(tc[2][1]) - D_W'(tc[0][1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            e1_reg  <= e1_next;
            e2_reg  <= e2_next;
            d1u_reg <= d1u_next;
            d1v_reg <= d1v_next;
            d2u_reg <= d2u_next;
            d2v_reg <= d2v_next;
        end
    end

    // Stage 2: determinant products and tangent cross terms.
    logic signed [2*D_W-1:0] da_reg, db_reg;
    logic signed [PRW-1:0]   na_reg [3], nb_reg [3];
    logic                    v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            da_reg <= d1u_reg * d2v_reg;
            db_reg <= d2u_reg * d1v_reg;
            for (int k = 0; k < 3; k++) begin
                na_reg[k] <= d2v_reg * PRW'(e1_reg[k]);
                nb_reg[k] <= d1v_reg * PRW'(e2_reg[k]);
            end
        end
    end

    // Stage 3: determinant sign, tangent components and their magnitudes.
    logic signed [DETW-1:0] det;
    logic signed [NW-1:0]   nv [3];
    logic [MW-1:0]          m3_next [3];
    logic [2:0]             neg3_next;
    logic [MW-1:0]          m3_reg [3];
    logic [2:0]             neg3_reg;
    logic                   dg3_reg, v3_reg;

    always_comb begin
        det = DETW'(da_reg) - DETW'(db_reg);
        for (int k = 0; k < 3; k++) begin
            nv[k]        = NW'(na_reg[k]) - NW'(nb_reg[k]);
            m3_next[k]   = nv[k][NW-1] ? MW'(-nv[k]) : MW'(nv[k]);
            neg3_next[k] = nv[k][NW-1] ^ det[DETW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            m3_reg   <= m3_next;
            neg3_reg <= neg3_next;
            dg3_reg  <= (det == '0);
        end
    end

    // Stage 4: largest magnitude.
    logic [MW-1:0] big_next, big4_reg;
    logic [MW-1:0] m4_reg [3];
    logic [2:0]    neg4_reg;
    logic          dg4_reg, v4_reg;

    always_comb begin
        big_next = m3_reg[0];
        if (m3_reg[1] > big_next) begin
            big_next = m3_reg[1];
        end
        if (m3_reg[2] > big_next) begin
            big_next = m3_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
        if (en) begin
            big4_reg <= big_next;
            m4_reg   <= m3_reg;
            neg4_reg <= neg3_reg;
            dg4_reg  <= dg3_reg || (big_next == '0);
        end
    end

    // Stage 5: position of the leading one of the largest magnitude.
    logic [PSW-1:0] lead_next, lead5_reg;
    logic [MW-1:0]  m5_reg [3];
    logic [2:0]     neg5_reg;
    logic           dg5_reg, v5_reg;

    always_comb begin
        lead_next = '0;
        for (int i = 0; i < MW; i++) begin
            if (big4_reg[i]) begin
                lead_next = PSW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
        if (en) begin
            lead5_reg <= lead_next;
            m5_reg    <= m4_reg;
            neg5_reg  <= neg4_reg;
            dg5_reg   <= dg4_reg;
        end
    end

    // Stage 6: shift every magnitude so that the largest has its top bit at 29.
    logic [MW+R_W-1:0] ext [3];
    logic [MW+R_W-1:0] shifted [3];
    logic [PSW-1:0]    rshift, lshift;
    side_t             side_next, side_reg;
    logic              v6_reg;

    always_comb begin
        rshift = lead5_reg - PSW'(R_TOP);
        lshift = PSW'(R_TOP) - lead5_reg;
        for (int k = 0; k < 3; k++) begin
            ext[k] = (MW + R_W)'(m5_reg[k]);
            if (lead5_reg >= PSW'(R_TOP)) begin
                shifted[k] = ext[k] >> rshift;
            end else begin
                shifted[k] = ext[k] << lshift;
            end
            side_next.r[k] = shifted[k][R_W-1:0];
        end
        side_next.neg   = neg5_reg;
        side_next.degen = dg5_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
        if (en) begin
            side_reg <= side_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_side  = side_reg;

endmodule

### src/ttv_sqrt.sv
// ============================================================================
// ttv_sqrt: pipelined length of the normalized tangent
// Squares and sums the magnitudes, then takes the integer square root one
// result bit per stage over 31 stages.
// ============================================================================
module ttv_sqrt (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  ttv_pkg::side_t          in_side,
    output logic                    out_valid,
    output ttv_pkg::side_t          out_side,
    output logic [ttv_pkg::L_W-1:0] out_len
);
    import ttv_pkg::*;

    // Squares of the three magnitudes.
    logic [SQ_W-1:0] sq_reg [3];
    side_t           sq_side_reg;
    logic            sq_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg <= 1'b0;
        end else if (en) begin
            sq_v_reg <= in_valid;
        end
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= SQ_W'(in_side.r[k]) * SQ_W'(in_side.r[k]);
            end
            sq_side_reg <= in_side;
        end
    end

    // Root stages; entry zero holds the sum of squares.
    logic [S_W-1:0]   rt_s_reg    [0:L_W];
    logic [REM_W-1:0] rt_rem_reg  [0:L_W];
    logic [L_W-1:0]   rt_root_reg [0:L_W];
    side_t            rt_side_reg [0:L_W];
    logic             rt_v_reg    [0:L_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rt_v_reg[0] <= 1'b0;
        end else if (en) begin
            rt_v_reg[0] <= sq_v_reg;
        end
        if (en) begin
            rt_s_reg[0]    <= S_W'(sq_reg[0]) + S_W'(sq_reg[1]) + S_W'(sq_reg[2]);
            rt_rem_reg[0]  <= '0;
            rt_root_reg[0] <= '0;
            rt_side_reg[0] <= sq_side_reg;
        end
    end

    for (genvar j = 0; j < L_W; j++) begin : g_root
        localparam int B = L_W - 1 - j;

        logic [REM_W+1:0] rem_sh, trial;
        logic [REM_W-1:0] rem_next;
        logic [L_W-1:0]   root_next;

        // One result bit: bring down two bits and try root*4+1.
        always_comb begin
            rem_sh = {rt_rem_reg[j], rt_s_reg[j][2*B+1 -: 2]};
            trial  = (REM_W + 2)'({rt_root_reg[j], 2'b01});
            if (rem_sh >= trial) begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {rt_root_reg[j][L_W-2:0], 1'b1};
            end else begin
                rem_next  = REM_W'(rem_sh);
                root_next = {rt_root_reg[j][L_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rt_v_reg[j+1] <= 1'b0;
            end else if (en) begin
                rt_v_reg[j+1] <= rt_v_reg[j];
            end
            if (en) begin
                rt_s_reg[j+1]    <= rt_s_reg[j];
                rt_rem_reg[j+1]  <= rem_next;
                rt_root_reg[j+1] <= root_next;
                rt_side_reg[j+1] <= rt_side_reg[j];
            end
        end
    end

    assign out_valid = rt_v_reg[L_W];
    assign out_side  = rt_side_reg[L_W];
    assign out_len   = rt_root_reg[L_W];

endmodule

### src/ttv_div.sv
// ============================================================================
// ttv_div: pipelined scaling of the tangent to unit length
// Divides 16384*r + L/2 by the length L in three lanes, one quotient bit per
// stage, then applies the signs, the clamp and the degenerate case.
// ============================================================================
module ttv_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  ttv_pkg::side_t          in_side,
    input  logic [ttv_pkg::L_W-1:0] in_len,
    output logic                    out_valid,
    output ttv_pkg::out_t           out_data
);
    import ttv_pkg::*;

    localparam int CMP_W = L_W + Q_W;

    // Entry zero holds the rounded numerators.
    logic [NUM_W-1:0] dv_rem_reg [0:Q_W][3];
    logic [Q_W-1:0]   dv_q_reg   [0:Q_W][3];
    logic [L_W-1:0]   dv_len_reg [0:Q_W];
    logic [2:0]       dv_neg_reg [0:Q_W];
    logic             dv_dg_reg  [0:Q_W];
    logic             dv_v_reg   [0:Q_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg[0] <= 1'b0;
        end else if (en) begin
            dv_v_reg[0] <= in_valid;
        end
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                dv_rem_reg[0][k] <= NUM_W'({in_side.r[k], {FRAC_BITS{1'b0}}})
                                    + NUM_W'(in_len >> 1);
                dv_q_reg[0][k]   <= '0;
            end
            dv_len_reg[0] <= in_len;
            dv_neg_reg[0] <= in_side.neg;
            dv_dg_reg[0]  <= in_side.degen || (in_len == '0);
        end
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_div
        localparam int B = Q_W - 1 - j;

        logic [CMP_W-1:0] den;
        logic [NUM_W-1:0] rem_next [3];
        logic [Q_W-1:0]   q_next   [3];

        // One quotient bit per lane: subtract L shifted to this weight.
        always_comb begin
            den = CMP_W'(dv_len_reg[j]) << B;
            for (int k = 0; k < 3; k++) begin
                q_next[k] = dv_q_reg[j][k];
                if (CMP_W'(dv_rem_reg[j][k]) >= den) begin
                    rem_next[k]  = NUM_W'(CMP_W'(dv_rem_reg[j][k]) - den);
                    q_next[k][B] = 1'b1;
                end else begin
                    rem_next[k] = dv_rem_reg[j][k];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[j+1] <= 1'b0;
            end else if (en) begin
                dv_v_reg[j+1] <= dv_v_reg[j];
            end
            if (en) begin
                dv_rem_reg[j+1] <= rem_next;
                dv_q_reg[j+1]   <= q_next;
                dv_len_reg[j+1] <= dv_len_reg[j];
                dv_neg_reg[j+1] <= dv_neg_reg[j];
                dv_dg_reg[j+1]  <= dv_dg_reg[j];
            end
        end
    end

    // Output register: clamp to one, restore signs, zero degenerate results.
    logic [Q_W-1:0] mag [3];
    logic [Q_W-1:0] comp [3];
    out_t           out_next, out_reg;
    logic           out_v_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag[k] = (dv_q_reg[Q_W][k] > ONE_Q14) ? ONE_Q14 : dv_q_reg[Q_W][k];
            if (dv_dg_reg[Q_W]) begin
                comp[k] = '0;
            end else if (dv_neg_reg[Q_W][k]) begin
                comp[k] = -mag[k];
            end else begin
                comp[k] = mag[k];
            end
        end
        out_next.tangent_x  = signed'(comp[0]);
        out_next.tangent_y  = signed'(comp[1]);
        out_next.tangent_z  = signed'(comp[2]);
        out_next.degenerate = dv_dg_reg[Q_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= dv_v_reg[Q_W];
        end
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

endmodule

### src/triangle_tangent_vector.sv
// ============================================================================
// triangle_tangent_vector: per-triangle unit tangent in fixed point
// Top level: front end, square-root pipeline and division pipeline.
// ============================================================================
// One triangle enters per clock cycle unless the pipeline holds, and passes
// through six stages of edge, determinant and normalization logic, two stages
// of squares, 31 square-root stages at one result bit each, one numerator
// stage, 16 division stages at one quotient bit each, and the output
// register. The whole pipeline advances together; it holds only when the
// output register carries a result that the downstream side has not taken,
// and then s_ready is low. A zero UV determinant or a zero-length tangent
// gives zero components with degenerate set.
module triangle_tangent_vector #(
    parameter int COORD_WIDTH = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ttv_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output ttv_pkg::out_t m_data
);
    import ttv_pkg::*;

    logic           en;
    logic           fr_valid, sq_valid;
    side_t          fr_side, sq_side;
    logic [L_W-1:0] sq_len;

    // Advance the pipeline unless the output transaction is stalled.
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    ttv_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (fr_valid),
        .out_side  (fr_side)
    );

    ttv_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_len   (sq_len)
    );

    ttv_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_side   (sq_side),
        .in_len    (sq_len),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

endmodule

### bench/tb_triangle_tangent_vector.sv
// ============================================================================
// tb_triangle_tangent_vector: self-checking bench for the tangent block
// Drives triangles through the valid/ready input channel, predicts each unit
// tangent with an independent fixed-point computation and compares every
// result transaction field by field, under several idle and stall mixes.
// ============================================================================
module tb_triangle_tangent_vector;
    import ttv_pkg::*;

    localparam int CW        = 16;
    localparam int WDOG_MAX  = 20000;
    localparam int LATENCY   = 60;

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    in_t   s_data = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    out_t  m_data;

    in_t   pending_tris[$];
    out_t  expected_tangents[$];
    int    error_count = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    bit    stim_done = 1'b0;
    int    quiet_cycles = 0;

    triangle_tangent_vector #(.COORD_WIDTH(CW)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    // Signed field extraction from a packed word.
    function automatic longint field_at(logic [63:0] word, int pos, int w);
        logic [63:0] v;
        v = (word >> pos) & ((64'd1 << w) - 1);
        if (v[w-1]) return longint'(v) - (longint'(1) << w);
        return longint'(v);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Unit tangent of one triangle.
    function automatic out_t unit_tangent(in_t tri_rec);
        out_t o;
        longint p[3][3];
        longint t[3][2];
        longint e1[3], e2[3], n[3];
        logic [63:0] r[3];
        logic [63:0] big, s, len, q;
        longint d1u, d1v, d2u, d2v, det;
        logic [63:0] pw[3];
        logic [63:0] tw[3];
        o = '0;
        o.degenerate = 1'b1;
        pw[0] = 64'(tri_rec.first_position);  pw[1] = 64'(tri_rec.second_position);
        pw[2] = 64'(tri_rec.third_position);
        tw[0] = 64'(tri_rec.first_uv); tw[1] = 64'(tri_rec.second_uv);
        tw[2] = 64'(tri_rec.third_uv);
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) p[i][k] = field_at(pw[i], k * CW, CW);
            for (int k = 0; k < 2; k++) t[i][k] = field_at(tw[i], k * UV_W, UV_W);
        end
        for (int k = 0; k < 3; k++) begin
            e1[k] = p[1][k] - p[0][k];
            e2[k] = p[2][k] - p[0][k];
        end
        d1u = t[1][0] - t[0][0];
        d1v = t[1][1] - t[0][1];
        d2u = t[2][0] - t[0][0];
        d2v = t[2][1] - t[0][1];
        det = d1u * d2v - d2u * d1v;
        if (det == 0) return o;
        big = '0;
        for (int k = 0; k < 3; k++) begin
            n[k] = d2v * e1[k] - d1v * e2[k];
            if (det < 0) n[k] = -n[k];
            r[k] = (n[k] < 0) ? 64'(-n[k]) : 64'(n[k]);
            if (r[k] > big) big = r[k];
        end
        if (big == 0) return o;
        while (big >= (64'd1 << 30)) begin
            big = big >> 1;
            for (int k = 0; k < 3; k++) r[k] = r[k] >> 1;
        end
        while (big < (64'd1 << 29)) begin
            big = big << 1;
            for (int k = 0; k < 3; k++) r[k] = r[k] << 1;
        end
        s = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
        len = int_sqrt(s);
        if (len == 0) return o;
        for (int k = 0; k < 3; k++) begin
            q = (64'd16384 * r[k] + (len >> 1)) / len;
            if (q > 64'd16384) q = 64'd16384;
            if (n[k] < 0) q = -q;
            if (k == 0) o.tangent_x = q[15:0];
            else if (k == 1) o.tangent_y = q[15:0];
            else o.tangent_z = q[15:0];
        end
        o.degenerate = 1'b0;
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Driver: presents the next pending triangle, holding it until accepted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (pending_tris.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data <= pending_tris[0];
                    expected_tangents = {expected_tangents, unit_tangent(pending_tris[0])};
                    void'(pending_tris.pop_front());
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction and drives the stall pattern.
    always @(posedge aclk) begin
        out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_tangents.size() == 0) begin
                    report_mismatch("unexpected transaction", 0, 0);
                end else begin
                    want = expected_tangents.pop_front();
                    if (m_data.tangent_x !== want.tangent_x)
                        report_mismatch("tangent_x", m_data.tangent_x, want.tangent_x);
                    if (m_data.tangent_y !== want.tangent_y)
                        report_mismatch("tangent_y", m_data.tangent_y, want.tangent_y);
                    if (m_data.tangent_z !== want.tangent_z)
                        report_mismatch("tangent_z", m_data.tangent_z, want.tangent_z);
                    if (m_data.degenerate !== want.degenerate)
                        report_mismatch("degenerate", m_data.degenerate, want.degenerate);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles with no accepted transaction on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (aresetn && !stim_done) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_MAX) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic logic [47:0] pack_pos(logic [15:0] x, logic [15:0] y,
                                             logic [15:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [47:0] rand_pos();
        return 48'({$urandom, $urandom});
    endfunction

    // Mostly small coordinates, with random spans reaching the full range.
    function automatic logic [15:0] rand_coord();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(64)) - 32);
            default: return 16'($signed($urandom_range(4096)) - 2048);
        endcase
    endfunction

    function automatic in_t rand_tri();
        in_t tri_rec;
        tri_rec.first_position  = ($urandom_range(9) == 0) ? rand_pos() :
            pack_pos(rand_coord(), rand_coord(), rand_coord());
        tri_rec.second_position = ($urandom_range(9) == 0) ? rand_pos() :
            pack_pos(rand_coord(), rand_coord(), rand_coord());
        tri_rec.third_position  = ($urandom_range(9) == 0) ? rand_pos() :
            pack_pos(rand_coord(), rand_coord(), rand_coord());
        tri_rec.first_uv  = {rand_coord(), rand_coord()};
        tri_rec.second_uv = ($urandom_range(15) == 0) ? tri_rec.first_uv :
            {rand_coord(), rand_coord()};
        tri_rec.third_uv  = {rand_coord(), rand_coord()};
        return tri_rec;
    endfunction

    task automatic wait_drained();
        while (pending_tris.size() > 0 || expected_tangents.size() > 0 || s_valid)
            @(posedge aclk);
    endtask

    initial begin
        in_t tri_rec;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: unit axes, extremes, degenerate cases.
        tri_rec = '0;
        tri_rec.second_position = pack_pos(16'd256, 16'd0, 16'd0);
        tri_rec.third_position  = pack_pos(16'd0, 16'd256, 16'd0);
        tri_rec.second_uv = {16'd0, 16'd4096};
        tri_rec.third_uv  = {16'd4096, 16'd0};
        pending_tris = {pending_tris, tri_rec};
        tri_rec.third_uv  = {16'hF000, 16'd0};         // negative determinant
        pending_tris = {pending_tris, tri_rec};
        tri_rec.third_uv  = {16'd8192, 16'd8192};      // positive determinant
        pending_tris = {pending_tris, tri_rec};
        tri_rec = '0;                                  // all zero
        pending_tris = {pending_tris, tri_rec};
        tri_rec.second_uv = {16'd0, 16'd4096};
        tri_rec.third_uv  = {16'd4096, 16'd0};         // zero-length tangent
        pending_tris = {pending_tris, tri_rec};
        tri_rec.first_position  = pack_pos(16'h8000, 16'h8000, 16'h8000);
        tri_rec.second_position = pack_pos(16'h7FFF, 16'h7FFF, 16'h7FFF);
        tri_rec.third_position  = pack_pos(16'h7FFF, 16'h8000, 16'h7FFF);
        tri_rec.first_uv  = {16'h8000, 16'h8000};
        tri_rec.second_uv = {16'h7FFF, 16'h8000};
        tri_rec.third_uv  = {16'h8000, 16'h7FFF};
        pending_tris = {pending_tris, tri_rec};
        tri_rec = '1;
        pending_tris = {pending_tris, tri_rec};
        tri_rec.third_uv = 32'h7FFF_0001;
        pending_tris = {pending_tris, tri_rec};
        tri_rec.first_position = 48'h0001_0000_0000;
        tri_rec.second_position = 48'h0000_0001_0000;
        pending_tris = {pending_tris, tri_rec};
        for (int i = 0; i < 12; i++) pending_tris = {pending_tris, rand_tri()};
        wait_drained();

        // Random phases with different idle and stall mixes.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 8 : 82) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 8 : 82) : 0;
            for (int i = 0; i < 430; i++) begin
                pending_tris = {pending_tris, rand_tri()};
                if (i % 100 == 0) begin
                    while (pending_tris.size() > 0) @(posedge aclk);
                end
            end
            // Pause the sender until every result has come back.
            wait_drained();
        end

        stim_done = 1'b1;
        repeat (LATENCY + 10) @(posedge aclk);
        if (error_count == 0 && expected_tangents.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
